### hw/rtl/assert_macros.svh
// Assertion helpers shared by the scheduler RTL.
// Both macros expect signals named clk and rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// A condition that must hold at every clock edge outside reset.
`define TGDS_CHECK(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("scheduler check failed");
// A consequence that must hold in the same cycle as its antecedent.
`define TGDS_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler implication failed");
`endif

### hw/rtl/tgds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgds_pkg: shared types and constants of the task graph scheduler
// Sizes of the vertex table, field widths, codes and the records that the
// engine keeps in its memories.
// ----------------------------------------------------------------------------
package tgds_pkg;

  localparam int MAX_TASKS      = 64;
  localparam int MAX_SUCCESSORS = 16;
  localparam int VID_W          = $clog2(MAX_TASKS);
  localparam int VCNT_W         = VID_W + 1;
  localparam int SIDX_W         = $clog2(MAX_SUCCESSORS);
  localparam int SCNT_W         = SIDX_W + 1;
  localparam int PEND_W         = 7;
  localparam int COUNT_W        = 7;
  localparam int KIND_W         = 4;
  localparam int ACT_W          = 3;
  localparam int REP_W          = 3;
  localparam int RESULT_LIMIT   = 64;
  localparam int ECNT_W         = $clog2(RESULT_LIMIT) + 1;
  localparam int IN_DATA_W      = 16;
  localparam int OUT_DATA_W     = 24;

  localparam logic [PEND_W-1:0]  PEND_LIMIT  = '1;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;

  localparam logic [KIND_W-1:0] KIND_SEND        = 4'd0;
  localparam logic [KIND_W-1:0] KIND_RECV        = 4'd1;
  localparam logic [KIND_W-1:0] KIND_MULTICAST   = 4'd2;
  localparam logic [KIND_W-1:0] KIND_WAIT        = 4'd7;
  localparam logic [KIND_W-1:0] KIND_RECV_REDUCE = 4'd8;
  localparam logic [KIND_W-1:0] KIND_LAST        = 4'd9;

  typedef enum logic [ACT_W-1:0] {
    ACT_CREATE = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_SEAL   = 3'd2,
    ACT_DONE   = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_t;

  typedef enum logic [REP_W-1:0] {
    REP_CREATED = 3'd0,
    REP_REMOTE  = 3'd1,
    REP_LOCAL   = 3'd2,
    REP_ACK     = 3'd3,
    REP_REJECT  = 3'd4
  } report_t;

  typedef enum logic [1:0] {
    PH_INIT     = 2'd0,
    PH_ISSUED   = 2'd1,
    PH_COMPLETE = 2'd2
  } phase_t;

  // One vertex table entry.
  typedef struct packed {
    phase_t              phase;
    logic [KIND_W-1:0]   kind;
    logic [PEND_W-1:0]   pend;
    logic [SCNT_W-1:0]   scnt;
  } vrec_t;

  // One cascade stack entry: vertex, next successor to visit, list length.
  typedef struct packed {
    logic [VID_W-1:0]  vid;
    logic [SCNT_W-1:0] nxt;
    logic [SCNT_W-1:0] cnt;
  } sent_t;

  typedef struct packed {
    report_t            report;
    logic [VID_W-1:0]   vertex;
    logic [KIND_W-1:0]  kind;
    logic [COUNT_W-1:0] count;
  } result_t;

  // Engine to result stage.
  typedef struct packed {
    logic    emit;
    logic    flush;
    result_t res;
  } res_ctl_t;

  // Result stage to engine.
  typedef struct packed {
    logic emit_ready;
    logic flush_ready;
  } res_stat_t;

  function automatic logic is_remote(input logic [KIND_W-1:0] kind);
    return (kind == KIND_SEND) || (kind == KIND_RECV) || (kind == KIND_MULTICAST) ||
           (kind == KIND_RECV_REDUCE);
  endfunction

endpackage

### hw/rtl/task_graph_dependency_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_graph_dependency_scheduler_top: dataflow dependency counting scheduler
// Builds a task graph of up to 64 vertices and issues vertices as their
// predecessors complete, reporting every creation, issue and completion.
// ----------------------------------------------------------------------------
// Items are taken one at a time. An item steps through the decode state and,
// as its action needs, the link, issue and completion cascade states; the
// cascade walks each edge and each finished vertex in turn, since every step
// is one access to the single-port vertex, successor or stack memory.
// Results leave through a holding register and an output register, so a
// stalled output stops the engine mid-item only when both are full, and the
// end of an item waits for the output register. Reset needs no clearing pass.
module task_graph_dependency_scheduler_top
  import tgds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // action [2:0], task_kind [6:3], vertex_ref [12:7]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // report [2:0], vertex_out [8:3], kind_out [12:9], completed_count [19:13]
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  res_ctl_t  ctl;
  res_stat_t stat;

  tgds_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (s_tdata[ACT_W-1:0]),
    .in_kind   (s_tdata[ACT_W+KIND_W-1:ACT_W]),
    .in_ref    (s_tdata[ACT_W+KIND_W+VID_W-1:ACT_W+KIND_W]),
    .ctl       (ctl),
    .stat      (stat)
  );

  tgds_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

### hw/rtl/tgds_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgds_out_stage: result holding and output register
// Keeps the newest result back until the next one or the end of the input
// is known, so that the final result of an input carries tlast.
// ----------------------------------------------------------------------------
module tgds_out_stage
  import tgds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  res_ctl_t              ctl,
  output res_stat_t             stat,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // report [2:0], vertex_out [8:3], kind_out [12:9], completed_count [19:13]
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  logic    pend_v;
  result_t pend;
  logic    ov, ov_next;
  result_t od;
  logic    olast;
  logic    out_free;

  assign out_free         = !ov || m_tready;
  assign stat.emit_ready  = !pend_v || out_free;
  assign stat.flush_ready = out_free;

  always_comb begin
    ov_next = ov && !m_tready;
    if ((ctl.emit && pend_v) || ctl.flush) begin
      ov_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      ov     <= 1'b0;
    end else begin
      ov <= ov_next;
      if (ctl.emit) begin
        pend_v <= 1'b1;
      end else if (ctl.flush) begin
        pend_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      pend <= ctl.res;
      if (pend_v) begin
        od    <= pend;
        olast <= 1'b0;
      end
    end else if (ctl.flush) begin
      od    <= pend;
      olast <= 1'b1;
    end
  end

  assign m_tvalid = ov;
  assign m_tlast  = olast;
  assign m_tdata  = {(OUT_DATA_W - REP_W - VID_W - KIND_W - COUNT_W)'(0),
                     od.count, od.kind, od.vertex, od.report};

endmodule

### hw/rtl/tgds_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgds_engine: graph sequencer over the vertex, successor and stack memories
// Decodes one item, reads and rewrites vertex entries one access a cycle when
// not stalled, and walks the completion cascade depth first through the stack.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tgds_engine
  import tgds_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [VID_W-1:0]  in_ref,
  output res_ctl_t          ctl,
  input  res_stat_t         stat
);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_DEC  = 14'b00000000000010,
    S_PRD  = 14'b00000000000100,
    S_CUR  = 14'b00000000001000,
    S_LINK = 14'b00000000010000,
    S_WRC  = 14'b00000000100000,
    S_ISS  = 14'b00000001000000,
    S_REP  = 14'b00000010000000,
    S_CTOP = 14'b00000100000000,
    S_CENT = 14'b00001000000000,
    S_CSUC = 14'b00010000000000,
    S_CREC = 14'b00100000000000,
    S_ACK  = 14'b01000000000000,
    S_FIN  = 14'b10000000000000
  } state_t;

  state_t              state, state_next;
  logic [ACT_W-1:0]    act;
  logic [KIND_W-1:0]   kind_in;
  logic [VID_W-1:0]    ref_in;
  logic [VCNT_W-1:0]   vt, vt_next;
  logic [COUNT_W-1:0]  ct, ct_next;
  logic [VCNT_W-1:0]   lw, lw_next;
  logic                vopen, vopen_next;
  logic [VCNT_W-1:0]   depth, depth_next;
  logic [ECNT_W-1:0]   ecnt;
  logic [VID_W-1:0]    pid, pid_next;
  logic [VID_W-1:0]    sid, sid_next;
  vrec_t               prec, prec_next;
  vrec_t               rec, rec_next;
  logic                linking, linking_next;
  logic [VID_W-1:0]    cur;
  logic [COUNT_W-1:0]  ct_inc;

  // Memories.
  vrec_t               vmem [MAX_TASKS];
  logic [VID_W-1:0]    smem [MAX_TASKS*MAX_SUCCESSORS];
  sent_t               stk  [MAX_TASKS];

  logic                vm_re, vm_we;
  logic [VID_W-1:0]    vm_ra, vm_wa;
  vrec_t               vm_wd, vm_rd;
  logic                sm_re, sm_we;
  logic [VID_W+SIDX_W-1:0] sm_ra, sm_wa;
  logic [VID_W-1:0]    sm_wd, sm_rd;
  logic                st_re, st_we;
  logic [VID_W-1:0]    st_ra, st_wa;
  sent_t               st_wd, st_rd;

  logic                em_want, em_need, go;
  result_t             em_res;
  vrec_t               r2;
  logic                push;
  logic [VID_W-1:0]    push_vid;
  logic [SCNT_W-1:0]   push_cnt;

  assign cur    = (vt == '0) ? '0 : VID_W'(vt - VCNT_W'(1));
  assign ct_inc = (ct < COUNT_LIMIT) ? ct + COUNT_W'(1) : ct;

  always_comb begin
    state_next   = state;
    vt_next      = vt;
    ct_next      = ct;
    lw_next      = lw;
    vopen_next   = vopen;
    depth_next   = depth;
    pid_next     = pid;
    sid_next     = sid;
    prec_next    = prec;
    rec_next     = rec;
    linking_next = linking;
    vm_re = 1'b0; vm_ra = '0; vm_we = 1'b0; vm_wa = '0; vm_wd = rec;
    sm_re = 1'b0; sm_ra = '0; sm_we = 1'b0; sm_wa = '0; sm_wd = '0;
    st_re = 1'b0; st_ra = '0; st_we = 1'b0; st_wa = '0; st_wd = '0;
    em_want  = 1'b0;
    em_res   = '{report: REP_REJECT, vertex: '0, kind: '0, count: ct};
    push     = 1'b0;
    push_vid = '0;
    push_cnt = '0;
    r2       = vm_rd;
    in_ready = 1'b0;
    ctl.flush = 1'b0;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        state_next = S_FIN;
        em_want    = 1'b1;
        unique case (act)
          ACT_CREATE: begin
            if (!vopen && vt < VCNT_W'(MAX_TASKS) && kind_in <= KIND_LAST) begin
              vm_we = 1'b1;
              vm_wa = VID_W'(vt);
              vm_wd = '{phase: PH_INIT, kind: kind_in, pend: '0, scnt: '0};
              vt_next    = vt + VCNT_W'(1);
              vopen_next = 1'b1;
              em_res = '{report: REP_CREATED, vertex: VID_W'(vt), kind: kind_in, count: ct};
            end
          end
          ACT_ADD: begin
            if (vopen && {1'b0, ref_in} < vt && ref_in != cur) begin
              em_want      = 1'b0;
              vm_re        = 1'b1;
              vm_ra        = ref_in;
              pid_next     = ref_in;
              linking_next = 1'b1;
              state_next   = S_PRD;
            end
          end
          ACT_SEAL: begin
            if (vopen) begin
              em_want = 1'b0;
              vm_re   = 1'b1;
              if (lw < vt && VID_W'(lw) != cur) begin
                vm_ra        = VID_W'(lw);
                pid_next     = VID_W'(lw);
                linking_next = 1'b1;
                state_next   = S_PRD;
              end else begin
                vm_ra        = cur;
                linking_next = 1'b0;
                state_next   = S_CUR;
              end
            end
          end
          ACT_DONE: begin
            if ({1'b0, ref_in} < vt) begin
              em_want    = 1'b0;
              vm_re      = 1'b1;
              vm_ra      = ref_in;
              state_next = S_REP;
            end
          end
          ACT_CLEAR: begin
            vt_next    = '0;
            ct_next    = '0;
            lw_next    = VCNT_W'(MAX_TASKS);
            vopen_next = 1'b0;
            depth_next = '0;
            em_res = '{report: REP_ACK, vertex: '0, kind: '0, count: '0};
          end
          default: begin
          end
        endcase
      end
      S_PRD: begin
        prec_next  = vm_rd;
        vm_re      = 1'b1;
        vm_ra      = cur;
        state_next = S_CUR;
      end
      S_CUR: begin
        rec_next   = vm_rd;
        state_next = linking ? S_LINK : S_ISS;
      end
      S_LINK: begin
        if (prec.scnt >= SCNT_W'(MAX_SUCCESSORS) ||
            (prec.phase != PH_COMPLETE && rec.pend >= PEND_LIMIT)) begin
          em_want    = 1'b1;
          state_next = S_FIN;
        end else begin
          sm_we = 1'b1;
          sm_wa = {pid, prec.scnt[SIDX_W-1:0]};
          sm_wd = cur;
          vm_we = 1'b1;
          vm_wa = pid;
          vm_wd = prec;
          vm_wd.scnt = prec.scnt + SCNT_W'(1);
          if (prec.phase != PH_COMPLETE) begin
            rec_next.pend = rec.pend + PEND_W'(1);
          end
          state_next = S_WRC;
        end
      end
      S_WRC: begin
        vm_we = 1'b1;
        vm_wa = cur;
        vm_wd = rec;
        if (act == ACT_ADD) begin
          em_want    = 1'b1;
          em_res     = '{report: REP_ACK, vertex: cur, kind: rec.kind, count: ct};
          state_next = S_FIN;
        end else begin
          state_next = S_ISS;
        end
      end
      S_ISS: begin
        if (rec.kind == KIND_WAIT) begin
          lw_next = {1'b0, cur};
        end
        vopen_next = 1'b0;
        state_next = S_CTOP;
        if (rec.phase == PH_INIT && rec.pend == '0) begin
          em_want = 1'b1;
          vm_we   = 1'b1;
          vm_wa   = cur;
          vm_wd   = rec;
          if (is_remote(rec.kind)) begin
            vm_wd.phase = PH_ISSUED;
            em_res = '{report: REP_REMOTE, vertex: cur, kind: rec.kind, count: ct};
          end else begin
            vm_wd.phase = PH_COMPLETE;
            ct_next  = ct_inc;
            em_res   = '{report: REP_LOCAL, vertex: cur, kind: rec.kind, count: ct_inc};
            push     = 1'b1;
            push_vid = cur;
            push_cnt = rec.scnt;
          end
        end
      end
      S_REP: begin
        em_want = 1'b1;
        if (vm_rd.phase == PH_ISSUED) begin
          vm_we = 1'b1;
          vm_wa = ref_in;
          vm_wd = vm_rd;
          vm_wd.phase = PH_COMPLETE;
          ct_next  = ct_inc;
          em_res   = '{report: REP_LOCAL, vertex: ref_in, kind: vm_rd.kind, count: ct_inc};
          push     = 1'b1;
          push_vid = ref_in;
          push_cnt = vm_rd.scnt;
          state_next = S_CTOP;
        end else begin
          state_next = S_FIN;
        end
      end
      S_CTOP: begin
        if (depth == '0) begin
          state_next = (act == ACT_SEAL && ecnt == '0) ? S_ACK : S_FIN;
        end else begin
          st_re      = 1'b1;
          st_ra      = VID_W'(depth - VCNT_W'(1));
          state_next = S_CENT;
        end
      end
      S_CENT: begin
        if (st_rd.nxt >= st_rd.cnt) begin
          depth_next = depth - VCNT_W'(1);
        end else begin
          st_we = 1'b1;
          st_wa = VID_W'(depth - VCNT_W'(1));
          st_wd = st_rd;
          st_wd.nxt = st_rd.nxt + SCNT_W'(1);
          sm_re = 1'b1;
          sm_ra = {st_rd.vid, st_rd.nxt[SIDX_W-1:0]};
          state_next = S_CSUC;
        end
        if (st_rd.nxt >= st_rd.cnt) begin
          state_next = S_CTOP;
        end
      end
      S_CSUC: begin
        state_next = S_CTOP;
        if ({1'b0, sm_rd} < vt) begin
          vm_re      = 1'b1;
          vm_ra      = sm_rd;
          sid_next   = sm_rd;
          state_next = S_CREC;
        end
      end
      S_CREC: begin
        // Lower the pending count; the open vertex is not issued before its seal.
        if (vm_rd.pend != '0) begin
          r2.pend = vm_rd.pend - PEND_W'(1);
        end
        if (r2.pend == '0 && !(vopen && sid == cur) && vm_rd.phase == PH_INIT) begin
          em_want = 1'b1;
          if (is_remote(vm_rd.kind)) begin
            r2.phase = PH_ISSUED;
            em_res = '{report: REP_REMOTE, vertex: sid, kind: vm_rd.kind, count: ct};
          end else begin
            r2.phase = PH_COMPLETE;
            ct_next  = ct_inc;
            em_res   = '{report: REP_LOCAL, vertex: sid, kind: vm_rd.kind, count: ct_inc};
            push     = 1'b1;
            push_vid = sid;
            push_cnt = vm_rd.scnt;
          end
        end
        vm_we      = 1'b1;
        vm_wa      = sid;
        vm_wd      = r2;
        state_next = S_CTOP;
      end
      S_ACK: begin
        em_want    = 1'b1;
        em_res     = '{report: REP_ACK, vertex: cur, kind: rec.kind, count: ct};
        state_next = S_FIN;
      end
      S_FIN: begin
        ctl.flush = stat.flush_ready;
        if (stat.flush_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (push && depth < VCNT_W'(MAX_TASKS)) begin
      st_we      = 1'b1;
      st_wa      = VID_W'(depth);
      st_wd      = '{vid: push_vid, nxt: '0, cnt: push_cnt};
      depth_next = depth + VCNT_W'(1);
    end

    // Results past the per-item limit are dropped, the state still moves on.
    ctl.emit = em_want && (ecnt < ECNT_W'(RESULT_LIMIT)) && stat.emit_ready;
    ctl.res  = em_res;
  end

  assign em_need  = em_want && (ecnt < ECNT_W'(RESULT_LIMIT));
  assign go       = !em_need || stat.emit_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      vt      <= '0;
      ct      <= '0;
      lw      <= VCNT_W'(MAX_TASKS);
      vopen   <= 1'b0;
      depth   <= '0;
      ecnt    <= '0;
      linking <= 1'b0;
    end else if (go) begin
      state   <= state_next;
      vt      <= vt_next;
      ct      <= ct_next;
      lw      <= lw_next;
      vopen   <= vopen_next;
      depth   <= depth_next;
      linking <= linking_next;
      if (state == S_IDLE) begin
        ecnt <= '0;
      end else if (ctl.emit) begin
        ecnt <= ecnt + ECNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      act     <= in_action;
      kind_in <= in_kind;
      ref_in  <= in_ref;
    end
    if (go) begin
      pid  <= pid_next;
      sid  <= sid_next;
      prec <= prec_next;
      rec  <= rec_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go && vm_we) begin
      vmem[vm_wa] <= vm_wd;
    end
    if (go && vm_re) begin
      vm_rd <= vmem[vm_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (go && sm_we) begin
      smem[sm_wa] <= sm_wd;
    end
    if (go && sm_re) begin
      sm_rd <= smem[sm_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (go && st_we) begin
      stk[st_wa] <= st_wd;
    end
    if (go && st_re) begin
      st_rd <= stk[st_ra];
    end
  end

  `TGDS_IMPLY(a_idle_stack_empty, state == S_IDLE, depth == '0)
  `TGDS_CHECK(a_vertex_bound, vt <= VCNT_W'(MAX_TASKS))
  `TGDS_CHECK(a_last_wait_valid, lw == VCNT_W'(MAX_TASKS) || lw < vt)
  `TGDS_IMPLY(a_emit_limit, ctl.emit, ecnt < ECNT_W'(RESULT_LIMIT))

endmodule
